// File: rtl/core/iopro_pkg.sv
package iopro_pkg;

    // default number of slots in the reorder window
    localparam int WINDOW_DEF = 32;

    // result status codes
    localparam logic [1:0] ST_EMIT      = 2'd0;
    localparam logic [1:0] ST_OUTSIDE   = 2'd1;
    localparam logic [1:0] ST_STALE     = 2'd2;
    localparam logic [1:0] ST_AFTER_END = 2'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       load;       // latch the incoming notice
        logic       calc_slot;  // register the slot of the notice
        logic       store;      // write the notice into its slot
        logic       read;       // read the slot of the next expected part
        logic       emit;       // emit the next expected part
        logic       err;        // emit an error result
        logic [1:0] err_code;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic finished;   // final part already emitted
        logic stale;      // notice is below the next expected part
        logic outside;    // notice lies beyond the window
        logic dup;        // slot of the notice already holds a part
        logic run_ready;  // next expected part present after the store
        logic emit_last;  // part being emitted ends the run
    } t_stat;

endpackage

// File: rtl/core/iopro_ctrl.sv
module iopro_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  iopro_pkg::t_stat i_stat,
    output logic            o_busy,
    output iopro_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_STORE = 5'b00100,
        S_READ  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.finished) begin
                    o_cmd.err      = 1'b1;
                    o_cmd.err_code = iopro_pkg::ST_AFTER_END;
                    n_state        = S_IDLE;
                end else if (i_stat.stale) begin
                    o_cmd.err      = 1'b1;
                    o_cmd.err_code = iopro_pkg::ST_STALE;
                    n_state        = S_IDLE;
                end else if (i_stat.outside) begin
                    o_cmd.err      = 1'b1;
                    o_cmd.err_code = iopro_pkg::ST_OUTSIDE;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.calc_slot = 1'b1;
                    n_state         = S_STORE;
                end
            end
            S_STORE: begin
                if (i_stat.dup) begin
                    o_cmd.err      = 1'b1;
                    o_cmd.err_code = iopro_pkg::ST_STALE;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.store = 1'b1;
                    n_state     = i_stat.run_ready ? S_READ : S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = i_stat.emit_last ? S_IDLE : S_READ;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: rtl/core/iopro_datapath.sv
module iopro_datapath #(
    parameter int WINDOW = iopro_pkg::WINDOW_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [63:0]      i_cfg_data,
    input  logic [31:0]      i_part_number,
    input  logic [31:0]      i_compressed_size,
    input  logic             i_is_final,
    input  iopro_pkg::t_cmd  i_cmd,
    output iopro_pkg::t_stat o_stat,
    output logic             o_strobe,
    output logic [1:0]       o_status,
    output logic [31:0]      o_out_part,
    output logic [31:0]      o_part_size,
    output logic [63:0]      o_part_offset,
    output logic             o_stream_done,
    output logic             o_last_of_run
);

    localparam int SW = $clog2(WINDOW);

    // latched notice
    logic [31:0]       r_part;
    logic [31:0]       r_size;
    logic              r_fin;
    logic [SW-1:0]     r_slot;

    // stream state
    logic [63:0]       r_base_offset;
    logic [31:0]       r_next;
    logic [SW-1:0]     r_next_slot;
    logic [SW-1:0]     n_next_slot;
    logic [63:0]       r_total;
    logic              r_finished;
    logic [WINDOW-1:0] r_valid;

    // slot memory: final flag over size
    logic [32:0]       r_mem [WINDOW];
    logic [32:0]       r_rd_data;

    // output registers
    logic              r_o_strobe;
    logic [1:0]        r_o_status;
    logic [31:0]       r_o_part;
    logic [31:0]       r_o_size;
    logic [63:0]       r_o_offset;
    logic              r_o_done;
    logic              r_o_last;

    logic [31:0]       part_gap;
    logic [SW:0]       slot_sum;

    // window distance and slot of the notice
    assign part_gap = r_part - r_next;
    assign slot_sum = {1'b0, r_next_slot} + {1'b0, part_gap[SW-1:0]};

    // slot of the part after the next expected one; 32-bit wrap restarts at slot 0
    always_comb begin
        if (r_next == '1) begin
            n_next_slot = '0;
        end else if (r_next_slot == SW'(WINDOW - 1)) begin
            n_next_slot = '0;
        end else begin
            n_next_slot = r_next_slot + SW'(1);
        end
    end

    // status to the controller
    always_comb begin
        o_stat.finished  = r_finished;
        o_stat.stale     = (r_part < r_next);
        o_stat.outside   = (part_gap >= 32'(WINDOW));
        o_stat.dup       = r_valid[r_slot];
        o_stat.run_ready = r_valid[r_next_slot] | (r_slot == r_next_slot);
        o_stat.emit_last = r_rd_data[32] | ~r_valid[n_next_slot];
    end

    // notice latch and slot index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_part <= i_part_number;
            r_size <= i_compressed_size;
            r_fin  <= i_is_final;
        end
        if (i_cmd.calc_slot) begin
            if (slot_sum >= (SW + 1)'(WINDOW)) begin
                r_slot <= SW'(slot_sum - (SW + 1)'(WINDOW));
            end else begin
                r_slot <= slot_sum[SW-1:0];
            end
        end
    end

    // slot memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[r_slot] <= {r_fin, r_size};
        end
        if (i_cmd.read) begin
            r_rd_data <= r_mem[r_next_slot];
        end
    end

    // stream state and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_offset <= '0;
            r_next        <= '0;
            r_next_slot   <= '0;
            r_total       <= '0;
            r_finished    <= 1'b0;
            r_valid       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_base_offset <= i_cfg_data;
            end
            if (i_cmd.store) begin
                r_valid[r_slot] <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_valid[r_next_slot] <= 1'b0;
                r_next      <= r_next + 32'd1;
                r_next_slot <= n_next_slot;
                r_total     <= r_total + {32'd0, r_rd_data[31:0]};
                if (r_rd_data[32]) begin
                    r_finished <= 1'b1;
                end
            end
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_strobe <= 1'b0;
        end else begin
            r_o_strobe <= i_cmd.err | i_cmd.emit;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.err) begin
            r_o_status <= i_cmd.err_code;
            r_o_part   <= r_part;
            r_o_size   <= '0;
            r_o_offset <= '0;
            r_o_done   <= 1'b0;
            r_o_last   <= 1'b1;
        end else if (i_cmd.emit) begin
            r_o_status <= iopro_pkg::ST_EMIT;
            r_o_part   <= r_next;
            r_o_size   <= r_rd_data[31:0];
            r_o_offset <= r_base_offset + r_total;
            r_o_done   <= r_rd_data[32];
            r_o_last   <= r_rd_data[32] | ~r_valid[n_next_slot];
        end
    end

    assign o_strobe      = r_o_strobe;
    assign o_status      = r_o_status;
    assign o_out_part    = r_o_part;
    assign o_part_size   = r_o_size;
    assign o_part_offset = r_o_offset;
    assign o_stream_done = r_o_done;
    assign o_last_of_run = r_o_last;

endmodule

// File: rtl/core/in_order_part_reorder_offsets_top.sv
// Part reorder buffer with offset assignment. A completion notice is taken when
// start is high and busy is low; busy then stays high until the last result of
// that notice is on the ports. Each result appears on the o_ ports for one cycle
// with o_strobe high and cannot be held off. A notice that is rejected gives one
// error result, also when it is a duplicate. A notice that is only stored gives
// no result. A notice that releases a run of n parts gives n results, read and
// emitted in turn: each drained part needs a read of the slot memory into a
// register before it can be emitted. base_offset (i_cfg_data with i_cfg_we) may
// be written only while busy is low; it applies to the next emitted part.
module in_order_part_reorder_offsets_top #(
    parameter int WINDOW = iopro_pkg::WINDOW_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_part_number,
    input  logic [31:0] i_compressed_size,
    input  logic        i_is_final,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [31:0] o_out_part,
    output logic [31:0] o_part_size,
    output logic [63:0] o_part_offset,
    output logic        o_stream_done,
    output logic        o_last_of_run
);

    iopro_pkg::t_cmd  cmd;
    iopro_pkg::t_stat stat;

    // sequencing
    iopro_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    // slot table, counters and result registers
    iopro_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_part_number     (i_part_number),
        .i_compressed_size (i_compressed_size),
        .i_is_final        (i_is_final),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_strobe          (o_strobe),
        .o_status          (o_status),
        .o_out_part        (o_out_part),
        .o_part_size       (o_part_size),
        .o_part_offset     (o_part_offset),
        .o_stream_done     (o_stream_done),
        .o_last_of_run     (o_last_of_run)
    );

`ifndef SYNTHESIS
    // an error result always closes its run
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != iopro_pkg::ST_EMIT) |-> o_last_of_run)
        else $error("error result without last_of_run");

    // the final part always closes its run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_stream_done) |-> o_last_of_run)
        else $error("final part without last_of_run");

    // no result in the cycle after a notice transfer
    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_strobe)
        else $error("result right after notice transfer");
`endif

endmodule
